>>> hw/rtl/cpc_pkg.sv
// shared constants, threshold table and widths for the cell pair contrast predictors
package cpc_pkg;

  // window geometry
  localparam int CELLS_PER_SIDE = 6;
  localparam int CELL_ROWS      = 8;
  localparam int CELL_WIDTH     = 50;
  localparam int CELL_HEIGHT    = 15;

  // field widths
  localparam int COLOR_W    = 8;
  localparam int COORD_W    = 11;
  localparam int OFS_W      = 8;
  localparam int PRED_W     = 21;
  localparam int ROW_OUT_W  = 3;
  localparam int DIST_OUT_W = 3;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = COORD_W;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_NEAR  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_FAR   = 2'd3;

  // register reset values
  localparam logic [COORD_W-1:0] WINDOW_TOP_RST  = COORD_W'(350);
  localparam logic [COORD_W-1:0] WINDOW_LEFT_RST = COORD_W'(20);
  localparam logic [OFS_W-1:0]   CLAMP_NEAR_RST  = OFS_W'(20);
  localparam logic [OFS_W-1:0]   CLAMP_FAR_RST   = OFS_W'(50);

  // cell store
  localparam int CELL_COUNT  = 2 * CELLS_PER_SIDE;
  localparam int IDX_W       = $clog2(CELL_COUNT);
  localparam int J_W         = (CELLS_PER_SIDE > 1) ? $clog2(CELLS_PER_SIDE) : 1;
  localparam int K_W         = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;
  localparam int CELL_PIXELS = CELL_WIDTH * CELL_HEIGHT;
  localparam int CELL_MAX    = 255 * CELL_PIXELS;
  localparam int SUM_W       = $clog2(CELL_MAX + 1);
  localparam int X_SPAN      = 2 * CELLS_PER_SIDE * CELL_WIDTH;
  localparam int Y_SPAN      = CELL_ROWS * CELL_HEIGHT;

  // cell index by reciprocal multiply, estimate low by at most one
  localparam int DIV_SH  = 16;
  localparam int RECIP_X = (1 << DIV_SH) / CELL_WIDTH;
  localparam int RECIP_Y = (1 << DIV_SH) / CELL_HEIGHT;
  localparam int PROD_W  = COORD_W + DIV_SH + 1;
  localparam int Q_W     = PROD_W - DIV_SH;

  // gray conversion, 14-bit weights
  localparam int GRAY_ACC_W = 22;
  localparam int GRAY_SH    = 14;
  localparam int GRAY_WB    = 1868;
  localparam int GRAY_WG    = 9617;
  localparam int GRAY_WR    = 4899;
  localparam int GRAY_RND   = 8192;

  // clamp and predictor scaling
  localparam int CLAMP_W   = SUM_W + 2;
  localparam logic signed [CLAMP_W-1:0] CELL_PIXELS_S = CLAMP_W'(CELL_PIXELS);
  localparam int DEN_SCALE = 20 * CELL_PIXELS;
  localparam int DEN_W     = $clog2(DEN_SCALE * 255 + 1);
  localparam int PRED_FRAC = 24;
  localparam int NUM_W     = SUM_W + PRED_FRAC + 1;
  localparam int QUOT_W    = PRED_W - 1;
  localparam int CNT_W     = $clog2(QUOT_W);

  // threshold table, rows by cell distance, columns by cell row
  localparam int THR_ROWS = 6;
  localparam int THR_COLS = 8;
  localparam logic [7:0] THR_TABLE [THR_ROWS][THR_COLS] = '{
    '{8'd170, 8'd180, 8'd190, 8'd200, 8'd210, 8'd220, 8'd220, 8'd220},
    '{8'd170, 8'd180, 8'd190, 8'd190, 8'd200, 8'd210, 8'd220, 8'd210},
    '{8'd165, 8'd170, 8'd180, 8'd190, 8'd190, 8'd200, 8'd200, 8'd200},
    '{8'd155, 8'd160, 8'd170, 8'd180, 8'd180, 8'd180, 8'd190, 8'd190},
    '{8'd145, 8'd150, 8'd150, 8'd160, 8'd160, 8'd170, 8'd170, 8'd170},
    '{8'd140, 8'd140, 8'd140, 8'd140, 8'd140, 8'd140, 8'd140, 8'd140}
  };

  // threshold lookup, indices saturate at the table edge
  function automatic logic [7:0] thr_lookup(input int j, input int k);
    logic [2:0] tj;
    logic [2:0] tk;
    tj = (j > THR_ROWS - 1) ? 3'(THR_ROWS - 1) : 3'(j);
    tk = (k > THR_COLS - 1) ? 3'(THR_COLS - 1) : 3'(k);
    return THR_TABLE[tj][tk];
  endfunction

endpackage

>>> hw/rtl/cell_pair_contrast_predictors_top.sv
// cell pair contrast predictors: gray accumulation per cell and predictor emission
//
// Pixels enter on the pixel channel (valid/ready) with their frame coordinates.
// Each pixel inside the window is converted to gray and added to its cell sum,
// held in a 12-entry memory with registered read data (read, add, write back).
// A pixel outside the window ends after the gray step; one inside also passes cell, read, add.
// After the bottom-right pixel of a cell row the block emits one result per
// cell distance on the result channel (valid/ready), nearest first; each result
// goes through a read of both cells, clamp, then a 20-step restoring divider,
// and no pixel is taken before the last result of the row is emitted.
// The cell sums then read as zero again.
// The result channel has an output register: a pending result does not block
// the next pixel; a stalled receiver only holds the next emit.
// Configuration writes (cfg channel) are always taken and apply at once; they
// are meant to happen while the block is idle.
// Reset (synchronous, active high) restores the register defaults, marks all
// cell sums as zero and drops result valid.
module cell_pair_contrast_predictors_top
  import cpc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [COLOR_W-1:0]            pixel_blue,
  input  logic [COLOR_W-1:0]            pixel_green,
  input  logic [COLOR_W-1:0]            pixel_red,
  input  logic [COORD_W-1:0]            pixel_column,
  input  logic [COORD_W-1:0]            pixel_row,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [PRED_W-1:0]      predictor_value,
  output logic [ROW_OUT_W-1:0]          cell_row,
  output logic [DIST_OUT_W-1:0]         cell_distance,
  output logic                          last_of_row
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_GRAY  = 4'd1;
  localparam logic [3:0] ST_CELL  = 4'd2;
  localparam logic [3:0] ST_READ  = 4'd3;
  localparam logic [3:0] ST_ACC   = 4'd4;
  localparam logic [3:0] ST_EREAD = 4'd5;
  localparam logic [3:0] ST_CLAMP = 4'd6;
  localparam logic [3:0] ST_PREP  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0] state;

  // configuration registers
  logic [COORD_W-1:0] window_top;
  logic [COORD_W-1:0] window_left;
  logic [OFS_W-1:0]   clamp_near_offset;
  logic [OFS_W-1:0]   clamp_far_offset;

  // pixel pipeline registers
  logic [COLOR_W-1:0]    pix_blue;
  logic [COLOR_W-1:0]    pix_green;
  logic [COLOR_W-1:0]    pix_red;
  logic [COORD_W-1:0]    pix_column;
  logic [COORD_W-1:0]    pix_row;
  logic [COORD_W-1:0]    x_off;
  logic [COORD_W-1:0]    y_off;
  logic [GRAY_ACC_W-1:0] prod_blue;
  logic [GRAY_ACC_W-1:0] prod_green;
  logic [GRAY_ACC_W-1:0] prod_red;
  logic [Q_W-1:0]        col_quot;
  logic [Q_W-1:0]        row_quot;
  logic [COLOR_W-1:0]    gray;
  logic [IDX_W-1:0]      cell_idx;
  logic [K_W-1:0]        row_idx;
  logic                  row_end;

  // cell store
  logic [SUM_W-1:0]      cell_mem [CELL_COUNT];
  logic [CELL_COUNT-1:0] cell_valid;
  logic [SUM_W-1:0]      rd_left;
  logic [SUM_W-1:0]      rd_right;
  logic                  rd_left_ok;
  logic                  rd_right_ok;

  // emission registers
  logic [J_W-1:0]            cell_j;
  logic signed [CLAMP_W-1:0] bound_lo;
  logic signed [CLAMP_W-1:0] bound_hi;
  logic [DEN_W-1:0]          den;
  logic [SUM_W-1:0]          diff_mag;
  logic                      diff_neg;
  logic [NUM_W-1:0]          rem;
  logic [NUM_W-1:0]          divisor;
  logic [QUOT_W-1:0]         quot;
  logic [CNT_W-1:0]          bit_cnt;

  // combinational values
  logic [COORD_W-1:0]        x_diff;
  logic [COORD_W-1:0]        y_diff;
  logic                      win_hit;
  logic [PROD_W-1:0]         col_prod;
  logic [PROD_W-1:0]         row_prod;
  logic [GRAY_ACC_W-1:0]     gray_sum;
  logic [COORD_W-1:0]        col_rem;
  logic [COORD_W-1:0]        row_rem;
  logic                      col_fix;
  logic                      row_fix;
  logic [Q_W-1:0]            col_cell;
  logic [Q_W-1:0]            row_cell;
  logic [COORD_W-1:0]        row_phase;
  logic [IDX_W-1:0]          addr_a;
  logic [IDX_W-1:0]          addr_b;
  logic [SUM_W-1:0]          acc_base;
  logic [SUM_W:0]            acc_wide;
  logic [SUM_W-1:0]          acc_sum;
  logic [7:0]                thr;
  logic signed [OFS_W:0]     far_gap;
  logic signed [OFS_W:0]     near_gap;
  logic signed [CLAMP_W-1:0] side_l;
  logic signed [CLAMP_W-1:0] side_r;
  logic signed [CLAMP_W:0]   diff;
  logic                      div_take;
  logic [QUOT_W-1:0]         quot_next;
  logic signed [PRED_W-1:0]  pred;
  logic                      dist_last;
  logic                      out_free;

  // clamp a cell sum into [lo, hi], upper bound wins when they cross
  function automatic logic signed [CLAMP_W-1:0] clamp_side(
    input logic [SUM_W-1:0]          s,
    input logic signed [CLAMP_W-1:0] lo,
    input logic signed [CLAMP_W-1:0] hi
  );
    logic signed [CLAMP_W-1:0] v;
    v = $signed({2'b00, s});
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  assign cfg_ready   = 1'b1;
  assign pixel_ready = (state == ST_IDLE);

  // window test and cell quotient estimates
  always_comb begin
    x_diff   = pix_column - window_left;
    y_diff   = pix_row - window_top;
    win_hit  = (pix_column >= window_left) && (pix_row >= window_top) &&
               (int'(x_diff) < X_SPAN) && (int'(y_diff) < Y_SPAN);
    col_prod = PROD_W'(x_diff) * PROD_W'(RECIP_X);
    row_prod = PROD_W'(y_diff) * PROD_W'(RECIP_Y);
  end

  // gray rounding and quotient correction
  always_comb begin
    gray_sum  = prod_blue + prod_green + prod_red + GRAY_ACC_W'(GRAY_RND);
    col_rem   = x_off - COORD_W'(col_quot * CELL_WIDTH);
    row_rem   = y_off - COORD_W'(row_quot * CELL_HEIGHT);
    col_fix   = int'(col_rem) >= CELL_WIDTH;
    row_fix   = int'(row_rem) >= CELL_HEIGHT;
    col_cell  = col_quot + Q_W'(col_fix);
    row_cell  = row_quot + Q_W'(row_fix);
    row_phase = row_fix ? row_rem - COORD_W'(CELL_HEIGHT) : row_rem;
  end

  // memory read addresses
  always_comb begin
    addr_a = (state == ST_READ) ? cell_idx
                                : IDX_W'(CELLS_PER_SIDE - 1) - IDX_W'(cell_j);
    addr_b = IDX_W'(CELLS_PER_SIDE) + IDX_W'(cell_j);
  end

  // saturating accumulate
  always_comb begin
    acc_base = rd_left_ok ? rd_left : '0;
    acc_wide = {1'b0, acc_base} + (SUM_W + 1)'(gray);
    acc_sum  = (int'(acc_wide) > CELL_MAX) ? SUM_W'(CELL_MAX) : acc_wide[SUM_W-1:0];
  end

  // clamp bounds, side difference and divider step
  always_comb begin
    thr       = thr_lookup(int'(cell_j), int'(row_idx));
    far_gap   = $signed({1'b0, thr}) - $signed({1'b0, clamp_far_offset});
    near_gap  = $signed({1'b0, thr}) - $signed({1'b0, clamp_near_offset});
    side_l    = clamp_side(rd_left_ok ? rd_left : '0, bound_lo, bound_hi);
    side_r    = clamp_side(rd_right_ok ? rd_right : '0, bound_lo, bound_hi);
    diff      = (CLAMP_W + 1)'(side_l) - (CLAMP_W + 1)'(side_r);
    div_take  = rem >= divisor;
    quot_next = {quot[QUOT_W-2:0], div_take};
    dist_last = int'(cell_j) == CELLS_PER_SIDE - 1;
    out_free  = !result_valid || result_ready;
    if (clamp_far_offset == '0) begin
      pred = '0;
    end else if (diff_neg) begin
      pred = -$signed({1'b0, quot});
    end else begin
      pred = $signed({1'b0, quot});
    end
  end

  // cell memory, two read ports with registered data
  always_ff @(posedge clk) begin
    if (state == ST_ACC) begin
      cell_mem[cell_idx] <= acc_sum;
    end
    rd_left     <= cell_mem[addr_a];
    rd_right    <= cell_mem[addr_b];
    rd_left_ok  <= cell_valid[addr_a];
    rd_right_ok <= cell_valid[addr_b];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_top        <= WINDOW_TOP_RST;
      window_left       <= WINDOW_LEFT_RST;
      clamp_near_offset <= CLAMP_NEAR_RST;
      clamp_far_offset  <= CLAMP_FAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_TOP:  window_top        <= cfg_data[COORD_W-1:0];
        REG_WINDOW_LEFT: window_left       <= cfg_data[COORD_W-1:0];
        REG_CLAMP_NEAR:  clamp_near_offset <= cfg_data[OFS_W-1:0];
        REG_CLAMP_FAR:   clamp_far_offset  <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cell_valid   <= '0;
      result_valid <= 1'b0;
      cell_j       <= '0;
    end else begin
      // result valid: set on an emit, cleared once the transfer is taken
      if (state == ST_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pixel_valid) begin
            state <= ST_GRAY;
          end
        end
        ST_GRAY: begin
          state <= win_hit ? ST_CELL : ST_IDLE;
        end
        ST_CELL: begin
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          cell_valid[cell_idx] <= 1'b1;
          cell_j               <= '0;
          state                <= row_end ? ST_EREAD : ST_IDLE;
        end
        ST_EREAD: begin
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          state <= ST_PREP;
        end
        ST_PREP: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (bit_cnt == '0) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            if (dist_last) begin
              cell_valid <= '0;
              state      <= ST_IDLE;
            end else begin
              cell_j <= cell_j + J_W'(1);
              state  <= ST_EREAD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // pixel datapath
  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      pix_blue   <= pixel_blue;
      pix_green  <= pixel_green;
      pix_red    <= pixel_red;
      pix_column <= pixel_column;
      pix_row    <= pixel_row;
    end
    if (state == ST_GRAY) begin
      x_off      <= x_diff;
      y_off      <= y_diff;
      prod_blue  <= GRAY_ACC_W'(pix_blue) * GRAY_ACC_W'(GRAY_WB);
      prod_green <= GRAY_ACC_W'(pix_green) * GRAY_ACC_W'(GRAY_WG);
      prod_red   <= GRAY_ACC_W'(pix_red) * GRAY_ACC_W'(GRAY_WR);
      col_quot   <= col_prod[PROD_W-1:DIV_SH];
      row_quot   <= row_prod[PROD_W-1:DIV_SH];
    end
    if (state == ST_CELL) begin
      gray     <= gray_sum[GRAY_SH +: COLOR_W];
      cell_idx <= IDX_W'(col_cell);
      row_idx  <= K_W'(row_cell);
      row_end  <= (int'(x_off) == X_SPAN - 1) && (int'(row_phase) == CELL_HEIGHT - 1);
    end
  end

  // emission datapath: bounds, clamp, divide, result register
  always_ff @(posedge clk) begin
    case (state)
      ST_EREAD: begin
        bound_lo <= CLAMP_W'(far_gap) * CELL_PIXELS_S;
        bound_hi <= CLAMP_W'(near_gap) * CELL_PIXELS_S;
        den      <= DEN_W'(clamp_far_offset) * DEN_W'(DEN_SCALE);
      end
      ST_CLAMP: begin
        diff_neg <= diff < 0;
        diff_mag <= (diff < 0) ? SUM_W'(-diff) : SUM_W'(diff);
      end
      ST_PREP: begin
        rem     <= NUM_W'({diff_mag, {PRED_FRAC{1'b0}}}) + NUM_W'(den >> 1);
        divisor <= NUM_W'(den) << (QUOT_W - 1);
        quot    <= '0;
        bit_cnt <= CNT_W'(QUOT_W - 1);
      end
      ST_DIV: begin
        if (div_take) begin
          rem <= rem - divisor;
        end
        quot    <= quot_next;
        divisor <= divisor >> 1;
        bit_cnt <= bit_cnt - CNT_W'(1);
      end
      ST_OUT: begin
        if (out_free) begin
          predictor_value <= pred;
          cell_row        <= ROW_OUT_W'(row_idx);
          cell_distance   <= DIST_OUT_W'(cell_j);
          last_of_row     <= dist_last;
        end
      end
      default: ;
    endcase
  end

endmodule
